// ===== hw/rtl/caption_char_encoder_assert.svh =====
// ---------------------------------------------------------------------------
// caption_char_encoder_assert.svh
// assertion macros used by the caption encoder checker
// ---------------------------------------------------------------------------
`ifndef CAPTION_CHAR_ENCODER_ASSERT_SVH
`define CAPTION_CHAR_ENCODER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CCE_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("caption_char_encoder: assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define CCE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("caption_char_encoder: assertion failed");

`endif

// ===== hw/rtl/cce_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cce_pkg
// types and constants of the caption character encoder
// ---------------------------------------------------------------------------
package cce_pkg;

    localparam int CP_W    = 32;
    localparam int LOGO_W  = 21;
    localparam int G2_N    = 96;
    localparam int G2_IDX_W = 7;

    localparam logic [7:0]  EXT1_BYTE   = 8'h10;
    localparam logic [7:0]  P16_BYTE    = 8'h18;
    localparam logic [7:0]  NOTE_BYTE   = 8'h7F;
    localparam logic [7:0]  LOGO_BYTE   = 8'hA0;
    localparam logic [7:0]  G2_BASE     = 8'h20;
    localparam logic [15:0] NOTE_CP     = 16'h266A;
    localparam logic [15:0] REPL_CP     = 16'hFFFD;
    localparam logic [5:0]  HI_SURR_TAG = 6'b110110;
    localparam logic [5:0]  LO_SURR_TAG = 6'b110111;
    localparam logic [LOGO_W-1:0] LOGO_RESET = 21'h00E000;

    localparam logic [2:0] CNT_ONE   = 3'd1;
    localparam logic [2:0] CNT_TWO   = 3'd2;
    localparam logic [2:0] CNT_THREE = 3'd3;
    localparam logic [2:0] CNT_SIX   = 3'd6;

    // G2 reverse table: codepoint carried by each G2 slot, zero when empty
    localparam logic [15:0] G2_MAP [G2_N] = '{
        16'h0020, 16'h00A0, 16'h0000, 16'h0000, 16'h0000, 16'h2026, 16'h0000, 16'h0000,
        16'h0000, 16'h0000, 16'h0160, 16'h0000, 16'h0152, 16'h0000, 16'h0000, 16'h0000,
        16'h25A0, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h0000, 16'h0000,
        16'h0000, 16'h2122, 16'h0161, 16'h0000, 16'h0153, 16'h2120, 16'h0000, 16'h0178,
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h215B, 16'h215C,
        16'h215D, 16'h215E, 16'h2502, 16'h2514, 16'h250C, 16'h2500, 16'h2510, 16'h2518
    };

    // G2 lookup outcome
    typedef struct packed {
        logic                hit;
        logic [G2_IDX_W-1:0] idx;
    } cce_g2_t;

    // one encoded character
    typedef struct packed {
        logic [5:0][7:0] bytes;
        logic [2:0]      count;
    } cce_result_t;

endpackage

// ===== hw/rtl/caption_char_encoder.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// caption_char_encoder
// unicode codepoint to caption wire byte encoder, one character per cycle
// ---------------------------------------------------------------------------
// Usage:
//   Drive codepoint and pulse start; a request is taken on any edge where
//   start is high and busy is low. busy stays low outside reset, so a new
//   request may be issued every cycle.
//   The request is captured in an input register, mapped by the rule logic
//   and caught in a result register: done rises as the result register is
//   loaded and holds for one cycle, and the result is taken in that cycle,
//   with byte_0..byte_5 and byte_count.
//   Throughput is one character per cycle; the input and result registers
//   sit around the single mapping pass.
//   Unused byte slots read zero. The receiver cannot stall: each result is
//   shown for one cycle only and must be taken then.
//   The logo codepoint register is written through cfg_valid/cfg_ready
//   (cfg_ready is always high); write it only while no request is in flight.
//   Reset clears the pipeline valid flags (no done pulses) and loads the logo
//   codepoint with U+E000.
// ---------------------------------------------------------------------------
module caption_char_encoder (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [cce_pkg::CP_W-1:0]   codepoint,
    output logic                       done,
    output logic [7:0]                 byte_0,
    output logic [7:0]                 byte_1,
    output logic [7:0]                 byte_2,
    output logic [7:0]                 byte_3,
    output logic [7:0]                 byte_4,
    output logic [7:0]                 byte_5,
    output logic [2:0]                 byte_count,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [cce_pkg::LOGO_W-1:0] cfg_data
);
    import cce_pkg::*;

    logic                in_valid_reg;
    logic [CP_W-1:0]     cp_reg;
    logic                out_valid_reg;
    cce_result_t         res_reg;
    cce_result_t         res_next;
    logic [LOGO_W-1:0]   logo_reg;
    logic                accept;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            logo_reg <= LOGO_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            logo_reg <= cfg_data;
        end
    end

    // valid flags of the two stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= accept;
            out_valid_reg <= in_valid_reg;
        end
    end

    // input capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cp_reg <= codepoint;
        end
    end

    // mapping pass
    cce_mapper u_map (
        .cp      (cp_reg),
        .logo_cp (logo_reg),
        .res     (res_next)
    );

    // result capture
    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign done       = out_valid_reg;
    assign byte_0     = res_reg.bytes[0];
    assign byte_1     = res_reg.bytes[1];
    assign byte_2     = res_reg.bytes[2];
    assign byte_3     = res_reg.bytes[3];
    assign byte_4     = res_reg.bytes[4];
    assign byte_5     = res_reg.bytes[5];
    assign byte_count = res_reg.count;

endmodule

// ===== hw/rtl/cce_g2_lookup.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cce_g2_lookup
// parallel match of a codepoint against the G2 reverse table
// ---------------------------------------------------------------------------
module cce_g2_lookup (
    input  logic [cce_pkg::CP_W-1:0] cp,
    output cce_pkg::cce_g2_t         g2
);
    import cce_pkg::*;

    logic upper_zero;

    assign upper_zero = (cp[CP_W-1:16] == '0);

    // table entries are unique, so at most one slot matches
    always_comb
    begin
        g2 = '0;
        for (int i = 0; i < G2_N; i++)
        begin
            if (upper_zero && (G2_MAP[i] != 16'h0000) && (G2_MAP[i] != 16'h0020)
                && (cp[15:0] == G2_MAP[i]))
            begin
                g2.hit = 1'b1;
                g2.idx = G2_IDX_W'(i);
            end
        end
    end

endmodule

// ===== hw/rtl/cce_mapper.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cce_mapper
// priority rules that turn one codepoint into caption wire bytes
// ---------------------------------------------------------------------------
module cce_mapper (
    input  logic [cce_pkg::CP_W-1:0]   cp,
    input  logic [cce_pkg::LOGO_W-1:0] logo_cp,
    output cce_pkg::cce_result_t       res
);
    import cce_pkg::*;

    cce_g2_t     g2;
    logic [19:0] supp;
    logic [15:0] hi_surr;
    logic [15:0] lo_surr;

    cce_g2_lookup u_g2 (
        .cp (cp),
        .g2 (g2)
    );

    // utf-16 pair for the supplementary planes
    assign supp    = 20'(cp[20:0] - 21'h010000);
    assign hi_surr = {HI_SURR_TAG, supp[19:10]};
    assign lo_surr = {LO_SURR_TAG, supp[9:0]};

    // first matching rule wins
    always_comb
    begin
        res = '0;
        if (cp == {16'h0000, NOTE_CP})
        begin
            res.bytes[0] = NOTE_BYTE;
            res.count    = CNT_ONE;
        end
        else if (cp inside {[32'h20:32'h7E], [32'hA0:32'hFF]})
        begin
            res.bytes[0] = cp[7:0];
            res.count    = CNT_ONE;
        end
        else if (g2.hit)
        begin
            res.bytes[0] = EXT1_BYTE;
            res.bytes[1] = G2_BASE + {1'b0, g2.idx};
            res.count    = CNT_TWO;
        end
        else if (cp == {11'd0, logo_cp})
        begin
            res.bytes[0] = EXT1_BYTE;
            res.bytes[1] = LOGO_BYTE;
            res.count    = CNT_TWO;
        end
        else if (cp <= 32'h0000FFFF)
        begin
            res.bytes[0] = P16_BYTE;
            if (cp inside {[32'hD800:32'hDFFF]})
            begin
                res.bytes[1] = REPL_CP[15:8];
                res.bytes[2] = REPL_CP[7:0];
            end
            else
            begin
                res.bytes[1] = cp[15:8];
                res.bytes[2] = cp[7:0];
            end
            res.count = CNT_THREE;
        end
        else if (cp <= 32'h0010FFFF)
        begin
            res.bytes[0] = P16_BYTE;
            res.bytes[1] = hi_surr[15:8];
            res.bytes[2] = hi_surr[7:0];
            res.bytes[3] = P16_BYTE;
            res.bytes[4] = lo_surr[15:8];
            res.bytes[5] = lo_surr[7:0];
            res.count    = CNT_SIX;
        end
        else
        begin
            res.bytes[0] = P16_BYTE;
            res.bytes[1] = REPL_CP[15:8];
            res.bytes[2] = REPL_CP[7:0];
            res.count    = CNT_THREE;
        end
    end

endmodule

// ===== hw/rtl/cce_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cce_checker
// port-level checks of the caption character encoder
// ---------------------------------------------------------------------------
`include "caption_char_encoder_assert.svh"

module cce_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [7:0] byte_0,
    input logic [7:0] byte_1,
    input logic [7:0] byte_2,
    input logic [7:0] byte_3,
    input logic [7:0] byte_4,
    input logic [7:0] byte_5,
    input logic [2:0] byte_count
);
    import cce_pkg::*;

    // every accepted request produces a result through the input and result registers
    `CCE_ASSERT_NEXT(a_req_to_done, $past(start && !busy), done)

    // no result without an earlier accepted request
    `CCE_ASSERT_IMPLY(a_done_has_req, done, $past(start && !busy, 2))

    // only the legal byte counts appear
    `CCE_ASSERT_IMPLY(a_count_legal, done,
        byte_count == CNT_ONE || byte_count == CNT_TWO || byte_count == CNT_THREE || byte_count == CNT_SIX)

    // single-byte results leave the other slots empty
    `CCE_ASSERT_IMPLY(a_one_byte_zero, done && byte_count == CNT_ONE,
        byte_1 == 8'h00 && byte_2 == 8'h00 && byte_3 == 8'h00 && byte_4 == 8'h00 && byte_5 == 8'h00)

    // six-byte results are two p16 triples
    `CCE_ASSERT_IMPLY(a_pair_framed, done && byte_count == CNT_SIX,
        byte_0 == P16_BYTE && byte_3 == P16_BYTE)

endmodule

bind caption_char_encoder cce_checker u_cce_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .byte_0     (byte_0),
    .byte_1     (byte_1),
    .byte_2     (byte_2),
    .byte_3     (byte_3),
    .byte_4     (byte_4),
    .byte_5     (byte_5),
    .byte_count (byte_count)
);

// ===== tb/tb_caption_char_encoder.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_caption_char_encoder
// self-checking bench for the caption character encoder
// ---------------------------------------------------------------------------
// A short table of hand-picked codepoints runs first: every mapping rule, the
// range edges, surrogates, values past the Unicode range and the logo glyph.
// Rows with an obvious answer carry it typed in; the rest go through the
// bench's own encoder model. Then the logo register is moved through a series
// of settings (zero, the top of Unicode, all ones, values shadowed by earlier
// rules, random) and each setting gets a burst of random codepoints, weighted
// toward the interesting ranges. Every done pulse is checked against the
// oldest pending request, byte by byte and count.
// ---------------------------------------------------------------------------
module tb_caption_char_encoder;

    import cce_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ITEMS   = 125;
    localparam int MAX_PRINTS    = 50;

    // G2 members as {slot, codepoint}; slot zero (space) never matches
    localparam logic [23:0] G2_ENTRIES [25] = '{
        24'h01_00A0, 24'h05_2026, 24'h0A_0160, 24'h0C_0152, 24'h10_25A0,
        24'h11_2018, 24'h12_2019, 24'h13_201C, 24'h14_201D, 24'h15_2022,
        24'h19_2122, 24'h1A_0161, 24'h1C_0153, 24'h1D_2120, 24'h1F_0178,
        24'h56_215B, 24'h57_215C, 24'h58_215D, 24'h59_215E, 24'h5A_2502,
        24'h5B_2514, 24'h5C_250C, 24'h5D_2500, 24'h5E_2510, 24'h5F_2518
    };

    // wire bytes, byte_0 in the top eight bits
    typedef struct packed {
        logic [47:0] seq;
        logic [2:0]  count;
    } wire_char_t;

    typedef struct {
        logic [31:0] cp;
        wire_char_t  want;
    } pending_char_t;

    typedef struct {
        logic [31:0] cp;
        bit          pinned;
        wire_char_t  want;
    } table_row_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [CP_W-1:0]   codepoint;
    logic              done;
    logic [7:0]        byte_0;
    logic [7:0]        byte_1;
    logic [7:0]        byte_2;
    logic [7:0]        byte_3;
    logic [7:0]        byte_4;
    logic [7:0]        byte_5;
    logic [2:0]        byte_count;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [LOGO_W-1:0] cfg_data;

    // typed-in expectation travels with the request
    bit                pinned_on;
    wire_char_t        pinned_char;

    logic [LOGO_W-1:0] logo_model = LOGO_RESET;
    logic [LOGO_W-1:0] logo_setting = LOGO_RESET;
    pending_char_t     pending_chars[$];
    table_row_t        char_table[$];
    int                mismatch_count = 0;
    bit                steady = 1'b0;

    caption_char_encoder DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .codepoint  (codepoint),
        .done       (done),
        .byte_0     (byte_0),
        .byte_1     (byte_1),
        .byte_2     (byte_2),
        .byte_3     (byte_3),
        .byte_4     (byte_4),
        .byte_5     (byte_5),
        .byte_count (byte_count),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // encoder model: rules tried in priority order
    function automatic wire_char_t encode_char(input logic [31:0] cp,
                                               input logic [LOGO_W-1:0] logo);
        wire_char_t  r;
        int          slot;
        logic [19:0] sup;
        logic [15:0] bmp;
        r    = '0;
        slot = -1;
        sup  = '0;
        bmp  = '0;
        foreach (G2_ENTRIES[i])
            if (cp == {16'h0, G2_ENTRIES[i][15:0]})
                slot = int'(G2_ENTRIES[i][23:16]);
        if (cp == {16'h0, NOTE_CP})
        begin
            r.seq[47:40] = NOTE_BYTE;
            r.count      = CNT_ONE;
        end
        else if ((cp >= 32'h20 && cp <= 32'h7E) || (cp >= 32'hA0 && cp <= 32'hFF))
        begin
            r.seq[47:40] = cp[7:0];
            r.count      = CNT_ONE;
        end
        else if (slot >= 0)
        begin
            r.seq[47:32] = {EXT1_BYTE, G2_BASE + 8'(slot)};
            r.count      = CNT_TWO;
        end
        else if (cp == {11'h0, logo})
        begin
            r.seq[47:32] = {EXT1_BYTE, LOGO_BYTE};
            r.count      = CNT_TWO;
        end
        else if (cp <= 32'h0010_FFFF && cp > 32'h0000_FFFF)
        begin
            // utf-16 pair, high surrogate first
            sup     = 20'(cp - 32'h0001_0000);
            r.seq   = {P16_BYTE, 16'hD800 + {6'h0, sup[19:10]},
                       P16_BYTE, 16'hDC00 + {6'h0, sup[9:0]}};
            r.count = CNT_SIX;
        end
        else
        begin
            // bmp triple; surrogates and out-of-range values become U+FFFD
            bmp = cp[15:0];
            if (cp > 32'h0000_FFFF || (cp >= 32'hD800 && cp <= 32'hDFFF))
                bmp = REPL_CP;
            r.seq[47:24] = {P16_BYTE, bmp};
            r.count      = CNT_THREE;
        end
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] cp,
                                 input logic [7:0] got, input logic [7:0] want);
        if (mismatch_count < MAX_PRINTS)
            $display("mismatch: %s cp=%h got=%h want=%h", what, cp, got, want);
        mismatch_count++;
    endtask

    // track requests and config writes, check each done pulse
    always @(posedge clk)
    begin
        pending_char_t head;
        logic [47:0]   got_seq;
        if (rst_n)
        begin
            if (done)
            begin
                got_seq = {byte_0, byte_1, byte_2, byte_3, byte_4, byte_5};
                if (pending_chars.size() == 0)
                    note_mismatch("result with nothing pending", '0, got_seq[47:40], '0);
                else
                begin
                    head = pending_chars.pop_front();
                    for (int i = 0; i < 6; i++)
                        if (got_seq[47-8*i -: 8] !== head.want.seq[47-8*i -: 8])
                            note_mismatch($sformatf("byte_%0d", i), head.cp,
                                          got_seq[47-8*i -: 8],
                                          head.want.seq[47-8*i -: 8]);
                    if (byte_count !== head.want.count)
                        note_mismatch("byte_count", head.cp, {5'h0, byte_count},
                                      {5'h0, head.want.count});
                end
            end
            if (cfg_valid && cfg_ready)
                logo_model = cfg_data;
            if (start && !busy)
            begin
                head.cp   = codepoint;
                head.want = pinned_on ? pinned_char : encode_char(codepoint, logo_model);
                pending_chars.push_back(head);
            end
        end
    end

    // issue one request, after a random idle gap outside steady stretches
    task automatic send_char(input logic [31:0] cp, input bit pin, input wire_char_t want);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        codepoint   <= cp;
        pinned_on   <= pin;
        pinned_char <= want;
        do @(posedge clk); while (busy);
    endtask

    // drain the pipe, then load a new logo codepoint
    task automatic write_logo(input logic [LOGO_W-1:0] value);
        start <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid    <= 1'b0;
        logo_setting  = value;
    endtask

    task automatic add_row(input logic [31:0] cp, input bit pin,
                           input logic [47:0] seq, input logic [2:0] count);
        table_row_t row;
        row.cp         = cp;
        row.pinned     = pin;
        row.want.seq   = seq;
        row.want.count = count;
        char_table.push_back(row);
    endtask

    // random codepoint, weighted toward the rule boundaries
    function automatic logic [31:0] pick_codepoint();
        logic [31:0] cp;
        case ($urandom_range(0, 11))
            0:       cp = {16'h0, NOTE_CP};
            1:       cp = $urandom_range(32'h20, 32'h7E);
            2:       cp = $urandom_range(32'hA0, 32'hFF);
            3:       cp = {16'h0, G2_ENTRIES[$urandom_range(0, 24)][15:0]};
            4:       cp = {11'h0, logo_setting};
            5:       cp = $urandom_range(0, 1) ? $urandom_range(0, 32'h1F)
                                               : $urandom_range(32'h7F, 32'h9F);
            6:       cp = $urandom_range(32'hD800, 32'hDFFF);
            7, 8:    cp = $urandom_range(0, 32'hFFFF);
            9, 10:   cp = $urandom_range(32'h0001_0000, 32'h0010_FFFF);
            default: cp = $urandom;
        endcase
        return cp;
    endfunction

    // stimulus
    initial
    begin
        logic [LOGO_W-1:0] logo_plan[$];
        rst_n       = 1'b0;
        start       = 1'b0;
        codepoint   = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        pinned_on   = 1'b0;
        pinned_char = '0;

        // directed table, reset logo
        add_row(32'h0000_0000, 1'b1, 48'h1800_0000_0000, CNT_THREE);
        add_row(32'h0000_001F, 1'b1, 48'h1800_1F00_0000, CNT_THREE);
        add_row(32'h0000_0020, 1'b1, 48'h2000_0000_0000, CNT_ONE);
        add_row(32'h0000_007E, 1'b1, 48'h7E00_0000_0000, CNT_ONE);
        add_row(32'h0000_007F, 1'b1, 48'h1800_7F00_0000, CNT_THREE);
        add_row(32'h0000_009F, 1'b1, 48'h1800_9F00_0000, CNT_THREE);
        add_row(32'h0000_00A0, 1'b1, 48'hA000_0000_0000, CNT_ONE);
        add_row(32'h0000_00FF, 1'b1, 48'hFF00_0000_0000, CNT_ONE);
        add_row(32'h0000_0100, 1'b1, 48'h1801_0000_0000, CNT_THREE);
        add_row(32'h0000_266A, 1'b1, 48'h7F00_0000_0000, CNT_ONE);
        add_row(32'h0000_2026, 1'b1, 48'h1025_0000_0000, CNT_TWO);
        add_row(32'h0000_2518, 1'b1, 48'h107F_0000_0000, CNT_TWO);
        add_row(32'h0000_0178, 1'b0, '0, '0);
        add_row(32'h0000_25A0, 1'b0, '0, '0);
        add_row(32'h0000_E000, 1'b1, 48'h10A0_0000_0000, CNT_TWO);
        add_row(32'h0000_D800, 1'b1, 48'h18FF_FD00_0000, CNT_THREE);
        add_row(32'h0000_DFFF, 1'b1, 48'h18FF_FD00_0000, CNT_THREE);
        add_row(32'h0000_FFFD, 1'b1, 48'h18FF_FD00_0000, CNT_THREE);
        add_row(32'h0000_FFFF, 1'b1, 48'h18FF_FF00_0000, CNT_THREE);
        add_row(32'h0001_0000, 1'b1, 48'h18D8_0018_DC00, CNT_SIX);
        add_row(32'h0010_FFFF, 1'b1, 48'h18DB_FF18_DFFF, CNT_SIX);
        add_row(32'h0001_F600, 1'b0, '0, '0);
        add_row(32'h0011_0000, 1'b1, 48'h18FF_FD00_0000, CNT_THREE);
        add_row(32'h8000_0000, 1'b1, 48'h18FF_FD00_0000, CNT_THREE);
        add_row(32'hFFFF_FFFF, 1'b1, 48'h18FF_FD00_0000, CNT_THREE);

        // logo settings: edges, shadowed values, then random
        logo_plan = '{LOGO_RESET, 21'h000000, 21'h10FFFF, 21'h1FFFFF,
                      21'h000041, 21'h002026, 21'h00D800};
        logo_plan.push_back(LOGO_W'($urandom_range(0, 32'h10FFFF)));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (char_table[i])
            send_char(char_table[i].cp, char_table[i].pinned, char_table[i].want);

        foreach (logo_plan[p])
        begin
            if (p > 0)
                write_logo(logo_plan[p]);
            // the logo itself and its neighbors
            send_char({11'h0, logo_setting}, 1'b0, '0);
            send_char({11'h0, logo_setting} + 32'd1, 1'b0, '0);
            send_char({11'h0, logo_setting} - 32'd1, 1'b0, '0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // some stretches run back to back
                if (n % 40 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                send_char(pick_codepoint(), 1'b0, '0);
            end
            steady = 1'b0;
        end
        start <= 1'b0;

        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
